// ----- rtl/core/clamped_linear_interpolation_table_top_assert.svh -----
// Assertion macros for the clamped interpolation table.
// Used by the top level only; needs nothing else.
`ifndef CLAMPED_LINEAR_INTERPOLATION_TABLE_TOP_ASSERT_SVH
`define CLAMPED_LINEAR_INTERPOLATION_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLTAB_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cltab: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLTAB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cltab: next-cycle check failed");

`endif

// ----- rtl/core/cltab_pkg.sv -----
// Shared types and constants for the clamped interpolation table.
// Used by cltab_ctrl, cltab_dpath and the top level; depends on nothing.
`default_nettype none

package cltab_pkg;

   localparam int DEF_TABLE_ROWS = 64;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;

   // width of one slice of the multiplicand taken per multiply step
   localparam int MUL_CHUNK = 16;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_RESULT
   } state_type;

   typedef enum logic [3:0] {
      OP_HOLD,
      OP_LOAD,
      OP_FIRST,
      OP_LAST,
      OP_SEARCH,
      OP_PREP,
      OP_MUL,
      OP_DIV,
      OP_SEND
   } op_type;

   typedef struct packed {
      logic first_hit;
      logic last_hit;
      logic more;
      logic mul_last;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/cltab_ctrl.sv -----
// Sequencer of the clamped interpolation table: handshakes and step order.
// Depends on cltab_pkg; drives cltab_dpath through an op code.
`default_nettype none

module cltab_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_command,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  cltab_pkg::dp_status_type dp_status,
   output cltab_pkg::op_type        dp_op
);

   cltab_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cltab_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dp_op        = cltab_pkg::OP_HOLD;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         cltab_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_op    = cltab_pkg::OP_LOAD;
               state_in = (req_command == cltab_pkg::CMD_LOOKUP) ?
                          cltab_pkg::ST_FIRST : cltab_pkg::ST_RESULT;
            end
         end
         cltab_pkg::ST_FIRST: begin
            dp_op    = cltab_pkg::OP_FIRST;
            state_in = dp_status.first_hit ? cltab_pkg::ST_RESULT : cltab_pkg::ST_LAST;
         end
         cltab_pkg::ST_LAST: begin
            dp_op = cltab_pkg::OP_LAST;
            if (dp_status.last_hit) begin
               state_in = cltab_pkg::ST_RESULT;
            end else if (dp_status.more) begin
               state_in = cltab_pkg::ST_SEARCH;
            end else begin
               state_in = cltab_pkg::ST_PREP;
            end
         end
         cltab_pkg::ST_SEARCH: begin
            dp_op = cltab_pkg::OP_SEARCH;
            if (!dp_status.more) begin
               state_in = cltab_pkg::ST_PREP;
            end
         end
         cltab_pkg::ST_PREP: begin
            dp_op    = cltab_pkg::OP_PREP;
            state_in = cltab_pkg::ST_MUL;
         end
         cltab_pkg::ST_MUL: begin
            dp_op = cltab_pkg::OP_MUL;
            if (dp_status.mul_last) begin
               state_in = cltab_pkg::ST_DIV;
            end
         end
         cltab_pkg::ST_DIV: begin
            dp_op = cltab_pkg::OP_DIV;
            if (dp_status.div_last) begin
               state_in = cltab_pkg::ST_RESULT;
            end
         end
         cltab_pkg::ST_RESULT: begin
            // load the output register only once its previous transfer is gone
            if (!rsp_valid_ff || rsp_tready) begin
               dp_op        = cltab_pkg::OP_SEND;
               rsp_valid_in = 1'b1;
               state_in     = cltab_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cltab_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cltab_dpath.sv -----
// Datapath of the clamped interpolation table: row memories, search registers,
// chunked multiplier and restoring divider. Depends on cltab_pkg.
`default_nettype none

module cltab_dpath #(
   parameter  int TABLE_ROWS = cltab_pkg::DEF_TABLE_ROWS,
   parameter  int KEY_BITS   = cltab_pkg::DEF_KEY_BITS,
   parameter  int VALUE_BITS = cltab_pkg::DEF_VALUE_BITS,
   localparam int ROW_BITS   = $clog2(TABLE_ROWS),
   localparam int CFG_BITS   = $clog2(TABLE_ROWS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cltab_pkg::op_type        dp_op,
   input  logic                     req_command,
   input  logic [ROW_BITS-1:0]      req_row,
   input  logic [KEY_BITS-1:0]      req_key,
   input  logic [VALUE_BITS-1:0]    req_entry,
   input  logic                     csr_we,
   input  logic [CFG_BITS-1:0]      csr_wdata,
   output cltab_pkg::dp_status_type dp_status,
   output logic [VALUE_BITS-1:0]    rsp_value,
   output logic                     rsp_status
);

   localparam int CHUNK     = cltab_pkg::MUL_CHUNK;
   localparam int MUL_STEPS = (VALUE_BITS + CHUNK - 1) / CHUNK;
   localparam int MAG_BITS  = MUL_STEPS * CHUNK;
   localparam int WORK_BITS = KEY_BITS + VALUE_BITS;
   localparam int SUM_BITS  = KEY_BITS + MAG_BITS;
   localparam int STEP_BITS = $clog2(VALUE_BITS);

   // row memories, one write and one registered read port each
   logic [KEY_BITS-1:0]   key_mem [TABLE_ROWS];
   logic [VALUE_BITS-1:0] val_mem [TABLE_ROWS];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [ROW_BITS-1:0]   rd_addr;
   logic                  mem_we;

   logic [ROW_BITS-1:0]   last_idx_ff, last_idx_in;
   logic [CFG_BITS-1:0]   rows_clamped;

   logic [ROW_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff;
   logic [ROW_BITS-1:0]   span, mid;
   logic [KEY_BITS-1:0]   q_ff, q_in, k_lo_ff, k_lo_in, k_hi_ff, k_hi_in;
   logic [KEY_BITS-1:0]   dq_ff, dq_in, dk_ff, dk_in;
   logic [VALUE_BITS-1:0] v_lo_ff, v_lo_in, v_hi_ff, v_hi_in;
   logic [MAG_BITS-1:0]   mag_ff, mag_in;
   logic                  rising_ff, rising_in;
   logic [WORK_BITS-1:0]  work_ff, work_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [VALUE_BITS-1:0] result_ff, result_in;
   logic                  status_ff, status_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                  out_status_ff, out_status_in;

   logic [KEY_BITS+CHUNK-1:0] prod;
   logic [SUM_BITS-1:0]       mul_sum;
   logic [KEY_BITS:0]         div_trial, div_diff;
   logic                      div_ge;
   logic [KEY_BITS-1:0]       rem_next;
   logic [VALUE_BITS-1:0]     quo;
   logic                      mul_last, div_last;

   // clamp the written row count to 2..TABLE_ROWS and keep the last index
   always_comb begin
      if (csr_wdata < CFG_BITS'(2)) begin
         rows_clamped = CFG_BITS'(2);
      end else if (csr_wdata > CFG_BITS'(TABLE_ROWS)) begin
         rows_clamped = CFG_BITS'(TABLE_ROWS);
      end else begin
         rows_clamped = csr_wdata;
      end
      last_idx_in = ROW_BITS'(rows_clamped - CFG_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= ROW_BITS'(1);
      end else if (csr_we) begin
         last_idx_ff <= last_idx_in;
      end
   end

   assign mem_we = (dp_op == cltab_pkg::OP_LOAD) && (req_command == cltab_pkg::CMD_WRITE)
                   && (req_row <= last_idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[req_row] <= req_key;
         val_mem[req_row] <= req_entry;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // multiply step: top slice of the magnitude times the key offset
   assign prod    = dq_ff * mag_ff[MAG_BITS-1 -: CHUNK];
   assign mul_sum = (SUM_BITS'(work_ff) << CHUNK) + SUM_BITS'(prod);

   // divide step: the upper part of the work register is the remainder
   assign div_trial = {work_ff[WORK_BITS-1:VALUE_BITS], work_ff[VALUE_BITS-1]};
   assign div_diff  = div_trial - {1'b0, dk_ff};
   assign div_ge    = div_trial >= {1'b0, dk_ff};
   assign rem_next  = div_ge ? div_diff[KEY_BITS-1:0] : div_trial[KEY_BITS-1:0];
   assign quo       = {work_ff[VALUE_BITS-2:0], div_ge};

   assign mul_last = step_ff == STEP_BITS'(MUL_STEPS - 1);
   assign div_last = step_ff == STEP_BITS'(VALUE_BITS - 1);

   always_comb begin
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      q_in          = q_ff;
      k_lo_in       = k_lo_ff;
      k_hi_in       = k_hi_ff;
      v_lo_in       = v_lo_ff;
      v_hi_in       = v_hi_ff;
      dq_in         = dq_ff;
      dk_in         = dk_ff;
      mag_in        = mag_ff;
      rising_in     = rising_ff;
      work_in       = work_ff;
      step_in       = step_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      case (dp_op)
         cltab_pkg::OP_HOLD: begin
         end
         cltab_pkg::OP_LOAD: begin
            q_in      = req_key;
            result_in = '0;
            status_in = (req_command == cltab_pkg::CMD_WRITE && req_row > last_idx_ff) ?
                        cltab_pkg::STATUS_REJECT : cltab_pkg::STATUS_OK;
         end
         cltab_pkg::OP_FIRST: begin
            lo_in     = '0;
            hi_in     = last_idx_ff;
            k_lo_in   = key_rd_ff;
            v_lo_in   = val_rd_ff;
            result_in = val_rd_ff;
         end
         cltab_pkg::OP_LAST: begin
            k_hi_in   = key_rd_ff;
            v_hi_in   = val_rd_ff;
            result_in = val_rd_ff;
         end
         cltab_pkg::OP_SEARCH: begin
            if (key_rd_ff <= q_ff) begin
               lo_in   = mid_ff;
               k_lo_in = key_rd_ff;
               v_lo_in = val_rd_ff;
            end else begin
               hi_in   = mid_ff;
               k_hi_in = key_rd_ff;
               v_hi_in = val_rd_ff;
            end
         end
         cltab_pkg::OP_PREP: begin
            dq_in     = q_ff - k_lo_ff;
            dk_in     = k_hi_ff - k_lo_ff;
            rising_in = v_hi_ff >= v_lo_ff;
            mag_in    = MAG_BITS'(rising_in ? (v_hi_ff - v_lo_ff) : (v_lo_ff - v_hi_ff));
            work_in   = '0;
            step_in   = '0;
         end
         cltab_pkg::OP_MUL: begin
            // every partial sum stays below the full product, so truncation is exact
            work_in = mul_sum[WORK_BITS-1:0];
            mag_in  = mag_ff << CHUNK;
            step_in = mul_last ? '0 : step_ff + STEP_BITS'(1);
         end
         cltab_pkg::OP_DIV: begin
            work_in = {rem_next, quo};
            step_in = step_ff + STEP_BITS'(1);
            if (div_last) begin
               result_in = rising_ff ? (v_lo_ff + quo) : (v_lo_ff - quo);
            end
         end
         cltab_pkg::OP_SEND: begin
            out_value_in  = result_ff;
            out_status_in = status_ff;
         end
         default: begin
         end
      endcase

      span = hi_in - lo_in;
      mid  = lo_in + (span >> 1);
      case (dp_op)
         cltab_pkg::OP_LOAD:  rd_addr = '0;
         cltab_pkg::OP_FIRST: rd_addr = last_idx_ff;
         default:             rd_addr = mid;
      endcase
   end

   always_comb begin
      dp_status.first_hit = q_ff <= key_rd_ff;
      dp_status.last_hit  = q_ff >= key_rd_ff;
      dp_status.more      = (hi_in - lo_in) > ROW_BITS'(1);
      dp_status.mul_last  = mul_last;
      dp_status.div_last  = div_last;
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= rd_addr;
      q_ff          <= q_in;
      k_lo_ff       <= k_lo_in;
      k_hi_ff       <= k_hi_in;
      v_lo_ff       <= v_lo_in;
      v_hi_ff       <= v_hi_in;
      dq_ff         <= dq_in;
      dk_ff         <= dk_in;
      mag_ff        <= mag_in;
      rising_ff     <= rising_in;
      work_ff       <= work_in;
      step_ff       <= step_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

endmodule

`default_nettype wire

// ----- rtl/core/clamped_linear_interpolation_table_top.sv -----
// Top level of the clamped piecewise-linear interpolation table.
// Instantiates cltab_ctrl and cltab_dpath; uses cltab_pkg and the assertion header.
//
//   channel  | dir | handshake                 | payload
//   ---------+-----+---------------------------+-----------------------------------------
//   req_     | in  | req_tvalid / req_tready   | tuser: command; tdata: row, key, entry
//   rsp_     | out | rsp_tvalid / rsp_tready   | tuser: status;  tdata: interpolated value
//   csr_     | in  | csr_we                    | csr_wdata: rows_in_use
//
// One item is in flight at a time. A write goes from the load step straight to the result.
// A lookup that clamps ends after the first-row or last-row compare; an interior lookup then
// runs a binary search of about log2 of the rows in use probes, one probe per cycle through
// the single memory read port, then a prep step, a 16-bit-slice multiplier and a
// one-bit-per-cycle divider. The output register lets a new item in while a result
// waits on rsp_tready. Reset is synchronous and sets rows_in_use to 2; the row memories
// are not cleared and rows must be written before lookups read them.
`default_nettype none

`include "clamped_linear_interpolation_table_top_assert.svh"

module clamped_linear_interpolation_table_top #(
   parameter  int TABLE_ROWS    = cltab_pkg::DEF_TABLE_ROWS,
   parameter  int KEY_BITS      = cltab_pkg::DEF_KEY_BITS,
   parameter  int VALUE_BITS    = cltab_pkg::DEF_VALUE_BITS,
   localparam int ROW_BITS      = $clog2(TABLE_ROWS),
   localparam int CFG_BITS      = $clog2(TABLE_ROWS + 1),
   localparam int REQ_DATA_BITS = ((ROW_BITS + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // row_index, key_value, entry_value from bit 0 up, zero padding on top
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // command
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // interpolated_value from bit 0 up, zero padding on top
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic                     rsp_tuser,
   input  logic                     csr_we,
   input  logic [CFG_BITS-1:0]      csr_wdata
);

   cltab_pkg::op_type        dp_op;
   cltab_pkg::dp_status_type dp_status;
   logic [VALUE_BITS-1:0]    rsp_value;
   logic                     req_xfer;
   logic                     dp_send;

   // sequencer: accepts a transfer only when idle, holds the result until taken
   cltab_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .dp_status   (dp_status),
      .dp_op       (dp_op)
   );

   // datapath: unpack the request fields straight from tdata
   cltab_dpath #(
      .TABLE_ROWS (TABLE_ROWS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .dp_op       (dp_op),
      .req_command (req_tuser),
      .req_row     (req_tdata[ROW_BITS-1:0]),
      .req_key     (req_tdata[ROW_BITS +: KEY_BITS]),
      .req_entry   (req_tdata[ROW_BITS+KEY_BITS +: VALUE_BITS]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .dp_status   (dp_status),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_tuser)
   );

   // zero-extend the value to whole bytes
   assign rsp_tdata = RSP_DATA_BITS'(rsp_value);

   assign req_xfer = req_tvalid && req_tready;
   assign dp_send  = (dp_op == cltab_pkg::OP_SEND);

   // a transfer in must close the input until that item's result has been loaded for output
   `CLTAB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_xfer, !req_tready)
   // the datapath latches the request exactly on the input transfer
   `CLTAB_ASSERT_NOW(a_load_on_transfer, clock, reset, req_xfer, dp_op == cltab_pkg::OP_LOAD)
   // never overwrite a result that is still waiting on the output
   `CLTAB_ASSERT_NOW(a_send_free_slot, clock, reset, dp_send, !rsp_tvalid || rsp_tready)
   // a loaded result is presented in the next cycle
   `CLTAB_ASSERT_NEXT(a_send_shows, clock, reset, dp_send, rsp_tvalid)

endmodule

`default_nettype wire
